/* design/dtam_pkg.sv */
// Package for the date-time minute adder: constants, status codes, controller
// states, command and status structs, and the month length helper.
// No dependencies.
package dtam_pkg;

    localparam int unsigned C_MIN_DAY       = 1440;
    localparam int unsigned C_MIN_HOUR      = 60;
    localparam int unsigned C_HOUR_DAY      = 24;
    localparam int unsigned C_DAYS_400      = 146097;
    localparam int unsigned C_YEARS_CYCLE   = 400;
    localparam int unsigned C_MOD_STEPS     = 6;
    localparam int unsigned C_DAYS_W        = 21;
    localparam int unsigned C_DIV_45        = 45;
    localparam int unsigned C_RECIP_45      = 95443718;
    localparam int unsigned C_RECIP_SHIFT   = 32;
    localparam int unsigned C_RECIP_15      = 547;
    localparam int unsigned C_RECIP15_SHIFT = 13;
    localparam int unsigned C_STEP_DIV      = 0;
    localparam int unsigned C_STEP_REM      = 1;
    localparam int unsigned C_STEP_HRS      = 2;
    localparam int unsigned C_STEP_MIN      = 3;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NEG_MIN   = 3'd1,
        ST_BAD_MONTH = 3'd2,
        ST_NEG_YEAR  = 3'd3,
        ST_BAD_DAY   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SETTLE,
        S_CYCLE,
        S_WALK,
        S_FIN
    } t_state;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       rem_step;
        logic       hrs_step;
        logic       min_step;
        logic       mod_step;
        logic       settle;
        logic       cyc_step;
        logic       walk_step;
        logic       emit;
        logic [2:0] shift;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic days_big;
        logic days_zero;
        logic out_blocked;
    } t_sts;

    function automatic logic [4:0] month_len(input logic [8:0] ymod, input logic [3:0] month);
        logic leap;
        leap = (ymod[1:0] == 2'b00) && (ymod != 9'd100) && (ymod != 9'd200)
               && (ymod != 9'd300);
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
            4'd2:                                       month_len = leap ? 5'd29 : 5'd28;
            default:                                    month_len = 5'd0;
        endcase
    endfunction

    function automatic logic [6:0] mod100(input logic [8:0] ymod);
        logic [8:0] v;
        v = ymod;
        if (v >= 9'd300) begin
            v = v - 9'd300;
        end else if (v >= 9'd200) begin
            v = v - 9'd200;
        end else if (v >= 9'd100) begin
            v = v - 9'd100;
        end
        mod100 = v[6:0];
    endfunction

endpackage

/* design/dtam_ctrl.sv */
// Controller of the date-time minute adder: sequences division, carries,
// 400-year steps and the month walk. Depends on dtam_pkg.
module dtam_ctrl
    import dtam_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.mod_step = 1'b1;
                o_cmd.div_step = (r_cnt == 3'(C_STEP_DIV));
                o_cmd.rem_step = (r_cnt == 3'(C_STEP_REM));
                o_cmd.hrs_step = (r_cnt == 3'(C_STEP_HRS));
                o_cmd.min_step = (r_cnt == 3'(C_STEP_MIN));
                o_cmd.shift    = 3'(C_MOD_STEPS - 1) - r_cnt;
                if (r_cnt == 3'(C_MOD_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_SETTLE;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_SETTLE: begin
                o_cmd.settle = 1'b1;
                n_state      = S_CYCLE;
            end
            S_CYCLE: begin
                if (i_sts.err) begin
                    n_state = S_FIN;
                end else if (i_sts.days_big) begin
                    o_cmd.cyc_step = 1'b1;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.days_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_FIN: begin
                if (!i_sts.out_blocked) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* design/dtam_dp.sv */
// Datapath of the date-time minute adder: reciprocal division by minutes per
// day and per hour, year reduction, calendar walk and output register.
// Depends on dtam_pkg.
module dtam_dp
    import dtam_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic signed [14:0] i_start_year,
    input  logic [3:0]         i_start_month,
    input  logic [4:0]         i_start_day,
    input  logic [4:0]         i_start_hour,
    input  logic [5:0]         i_start_minute,
    input  logic signed [31:0] i_add_minutes,
    input  logic               i_out_stall,
    output t_sts               o_sts,
    output logic               o_out_valid,
    output logic [13:0]        o_result_year,
    output logic [3:0]         o_result_month,
    output logic [4:0]         o_result_day,
    output logic [4:0]         o_result_hour,
    output logic [5:0]         o_result_minute,
    output logic [2:0]         o_status
);

    logic [14:0]         r_year, n_year;
    logic [13:0]         r_ymod, n_ymod;
    logic [3:0]          r_month, n_month;
    logic [4:0]          r_day, n_day;
    logic [4:0]          r_hour, n_hour;
    logic [5:0]          r_minute, n_minute;
    logic [30:0]         r_add, n_add;
    logic [C_DAYS_W-1:0] r_div, n_div;
    logic [10:0]         r_rem, n_rem;
    logic [4:0]          r_hrs, n_hrs;
    logic [C_DAYS_W-1:0] r_days, n_days;
    t_status             r_stat, n_stat;
    logic                r_min_neg, r_year_neg, r_two;
    logic                r_out_valid;
    logic [13:0]         r_o_year;
    logic [3:0]          r_o_month;
    logic [4:0]          r_o_day, r_o_hour;
    logic [5:0]          r_o_minute;
    t_status             r_o_stat;

    logic [52:0]         q_prod;
    logic [25:0]         r45;
    logic [17:0]         hrs_prod;
    logic [10:0]         min_rem;
    logic [13:0]         ymod_lim;
    logic [6:0]          min_sum;
    logic [5:0]          hour_sum;
    logic                min_carry, hour_carry;
    logic [4:0]          mlen;
    logic [5:0]          rest;

    assign mlen = month_len(r_ymod[8:0], r_month);
    assign rest = 6'(mlen) - 6'(r_day) + 6'd1;

    always_comb begin
        n_year   = r_year;
        n_ymod   = r_ymod;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_add    = r_add;
        n_div    = r_div;
        n_rem    = r_rem;
        n_hrs    = r_hrs;
        n_days   = r_days;
        n_stat   = r_stat;

        q_prod     = 53'(r_add[30:5]) * 53'(C_RECIP_45);
        r45        = r_add[30:5] - (26'(r_div) * 26'(C_DIV_45));
        hrs_prod   = 18'(r_rem[10:2]) * 18'(C_RECIP_15);
        min_rem    = r_rem - (11'(r_hrs) * 11'(C_MIN_HOUR));
        ymod_lim   = 14'(C_YEARS_CYCLE) << i_cmd.shift;
        min_sum    = 7'(r_minute) + 7'(r_rem[5:0]);
        min_carry  = (min_sum > 7'(C_MIN_HOUR - 1));
        hour_sum   = 6'(r_hour) + 6'(r_hrs) + 6'(min_carry);
        hour_carry = (hour_sum > 6'(C_HOUR_DAY - 1));

        if (i_cmd.load) begin
            n_year   = {1'b0, i_start_year[13:0]};
            n_ymod   = i_start_year[13:0];
            n_month  = i_start_month;
            n_day    = i_start_day;
            n_hour   = i_start_hour;
            n_minute = i_start_minute;
            n_add    = i_add_minutes[30:0];
            n_div    = '0;
            n_rem    = '0;
            n_hrs    = '0;
        end

        if (i_cmd.div_step) begin
            n_div = q_prod[C_RECIP_SHIFT +: C_DAYS_W];
        end

        if (i_cmd.rem_step) begin
            n_rem = {r45[5:0], r_add[4:0]};
        end

        if (i_cmd.hrs_step) begin
            n_hrs = hrs_prod[C_RECIP15_SHIFT +: 5];
        end

        if (i_cmd.min_step) begin
            n_rem = min_rem;
        end

        if (i_cmd.mod_step && (r_ymod >= ymod_lim)) begin
            n_ymod = r_ymod - ymod_lim;
        end

        if (i_cmd.settle) begin
            priority if (r_min_neg) begin
                n_stat = ST_NEG_MIN;
            end else if ((r_month < 4'd1) || (r_month > 4'd12)) begin
                n_stat = ST_BAD_MONTH;
            end else if (r_year_neg) begin
                n_stat = ST_NEG_YEAR;
            end else if ((r_day < 5'd1) || (r_day > mlen)) begin
                n_stat = ST_BAD_DAY;
            end else begin
                n_stat = ST_OK;
            end
            n_minute = min_carry ? 6'(min_sum - 7'(C_MIN_HOUR)) : min_sum[5:0];
            n_hour   = hour_carry ? 5'(hour_sum - 6'(C_HOUR_DAY)) : hour_sum[4:0];
            n_days   = r_div + C_DAYS_W'(hour_carry);
        end

        if (i_cmd.cyc_step) begin
            n_days = r_days - C_DAYS_W'(C_DAYS_400);
            n_year = r_year + 15'(C_YEARS_CYCLE);
        end

        if (i_cmd.walk_step) begin
            if (r_days >= C_DAYS_W'(rest)) begin
                n_days = r_days - C_DAYS_W'(rest);
                n_day  = 5'd1;
                if (r_month == 4'd12) begin
                    n_month = 4'd1;
                    n_year  = r_year + 15'd1;
                    n_ymod  = (r_ymod == 14'(C_YEARS_CYCLE - 1)) ? '0 : r_ymod + 14'd1;
                end else begin
                    n_month = r_month + 4'd1;
                end
            end else begin
                n_day  = r_day + r_days[4:0];
                n_days = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_year   <= n_year;
        r_ymod   <= n_ymod;
        r_month  <= n_month;
        r_day    <= n_day;
        r_hour   <= n_hour;
        r_minute <= n_minute;
        r_add    <= n_add;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_hrs    <= n_hrs;
        r_days   <= n_days;
        r_stat   <= n_stat;
        if (i_cmd.load) begin
            r_min_neg  <= i_add_minutes[31];
            r_year_neg <= i_start_year[14];
            r_two      <= (i_start_year < 15'sd100);
        end
        if (i_cmd.emit) begin
            r_o_stat <= r_stat;
            if (r_stat != ST_OK) begin
                r_o_year   <= '0;
                r_o_month  <= '0;
                r_o_day    <= '0;
                r_o_hour   <= '0;
                r_o_minute <= '0;
            end else begin
                r_o_year   <= r_two ? 14'(mod100(r_ymod[8:0])) : r_year[13:0];
                r_o_month  <= r_month;
                r_o_day    <= r_day;
                r_o_hour   <= r_hour;
                r_o_minute <= r_minute;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.err         = (r_stat != ST_OK);
    assign o_sts.days_big    = (r_days >= C_DAYS_W'(C_DAYS_400));
    assign o_sts.days_zero   = (r_days == '0);
    assign o_sts.out_blocked = r_out_valid && i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_result_year   = r_o_year;
    assign o_result_month  = r_o_month;
    assign o_result_day    = r_o_day;
    assign o_result_hour   = r_o_hour;
    assign o_result_minute = r_o_minute;
    assign o_status        = r_o_stat;

endmodule

/* design/date_time_add_minutes_unit.sv */
// Top level of the date-time minute adder: controller and datapath.
// Depends on dtam_pkg, dtam_ctrl and dtam_dp.
//
// Channel   Direction  Handshake                 Fields
// input     in         i_in_valid / o_in_stall   start year, month, day, hour, minute, add
// output    out        o_out_valid / i_out_stall result year, month, day, hour, minute, status
//
// After acceptance an item passes the reciprocal division and year reduction steps, a settle
// step, one step per whole 400-year cycle removed and then the month walk: one step per
// month end crossed, plus one when the walk stops inside a month. An error skips the
// 400-year steps and the walk. The walk crosses one month end per cycle.
// Reset clears the controller and the output valid; no clearing pass is needed.
// A finished result waits in the output register while the next item is accepted.
module date_time_add_minutes_unit
    import dtam_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [14:0] i_start_year,
    input  logic [3:0]         i_start_month,
    input  logic [4:0]         i_start_day,
    input  logic [4:0]         i_start_hour,
    input  logic [5:0]         i_start_minute,
    input  logic signed [31:0] i_add_minutes,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [13:0]        o_result_year,
    output logic [3:0]         o_result_month,
    output logic [4:0]         o_result_day,
    output logic [4:0]         o_result_hour,
    output logic [5:0]         o_result_minute,
    output logic [2:0]         o_status
);

    t_cmd cmd;
    t_sts sts;

    dtam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    dtam_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_start_year    (i_start_year),
        .i_start_month   (i_start_month),
        .i_start_day     (i_start_day),
        .i_start_hour    (i_start_hour),
        .i_start_minute  (i_start_minute),
        .i_add_minutes   (i_add_minutes),
        .i_out_stall     (i_out_stall),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .o_result_year   (o_result_year),
        .o_result_month  (o_result_month),
        .o_result_day    (o_result_day),
        .o_result_hour   (o_result_hour),
        .o_result_minute (o_result_minute),
        .o_status        (o_status)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Input was not stalled after an item was accepted.");

    a_error_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |->
        ((o_result_year == '0) && (o_result_month == '0) && (o_result_day == '0)
         && (o_result_hour == '0) && (o_result_minute == '0)))
        else $error("An error result carries nonzero date fields.");

    a_ok_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_OK)) |->
        ((o_result_month >= 4'd1) && (o_result_month <= 4'd12) && (o_result_day >= 5'd1)))
        else $error("A good result has a month or day out of range.");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("A result appeared while the block was idle.");

endmodule

/* verif/tb.sv */
// Self-checking testbench for date_time_add_minutes_unit: directed table, then random items.
// Expected results: table values or an in-file calendar predictor; depends on dtam_pkg and the RTL.
module tb;
    import dtam_pkg::*;

    localparam int QUIET_LIMIT = 50000;
    localparam int ITEMS_PER_PHASE = 112;

    typedef struct {
        logic signed [14:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic signed [31:0] add;
    } t_start;

    typedef struct {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        t_status     status;
    } t_stamp;

    typedef struct {
        t_start start;
        bit     known;
        t_stamp want;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [14:0] i_start_year = '0;
    logic [3:0]         i_start_month = '0;
    logic [4:0]         i_start_day = '0;
    logic [4:0]         i_start_hour = '0;
    logic [5:0]         i_start_minute = '0;
    logic signed [31:0] i_add_minutes = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [13:0]        o_result_year;
    logic [3:0]         o_result_month;
    logic [4:0]         o_result_day;
    logic [4:0]         o_result_hour;
    logic [5:0]         o_result_minute;
    logic [2:0]         o_status;

    t_stamp pending_stamps[$];
    t_row   directed_rows[$];
    t_stamp oldest;
    int     errors = 0;
    int     quiet_cycles = 0;
    int     send_idle_pct = 0;
    int     stall_pct = 0;
    int     idle_plan[4] = '{0, 79, 0, 27};
    int     stall_plan[4] = '{0, 0, 79, 27};

    date_time_add_minutes_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_start_year    (i_start_year),
        .i_start_month   (i_start_month),
        .i_start_day     (i_start_day),
        .i_start_hour    (i_start_hour),
        .i_start_minute  (i_start_minute),
        .i_add_minutes   (i_add_minutes),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_year   (o_result_year),
        .o_result_month  (o_result_month),
        .o_result_day    (o_result_day),
        .o_result_hour   (o_result_hour),
        .o_result_minute (o_result_minute),
        .o_status        (o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
        bit leap;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic t_stamp advance_stamp(t_start s);
        t_stamp      r;
        int unsigned yr, mon, dy, hr, mn, addu, hrs, days, mlen;
        bit          two_digit;
        r.year = '0;
        r.month = '0;
        r.day = '0;
        r.hour = '0;
        r.minute = '0;
        r.status = ST_OK;
        yr = {17'd0, s.year};
        mon = 32'(s.month);
        dy = 32'(s.day);
        hr = 32'(s.hour);
        mn = 32'(s.minute);
        addu = s.add;
        if (s.add < 0) begin
            r.status = ST_NEG_MIN;
        end else if (mon < 1 || mon > 12) begin
            r.status = ST_BAD_MONTH;
        end else if (s.year[14]) begin
            r.status = ST_NEG_YEAR;
        end else if (dy < 1 || dy > days_in_month(yr, mon)) begin
            r.status = ST_BAD_DAY;
        end
        if (r.status != ST_OK) begin
            return r;
        end
        two_digit = yr < 100;
        mn += addu % C_MIN_HOUR;
        hrs = (addu / C_MIN_HOUR) % C_HOUR_DAY;
        days = addu / C_MIN_DAY;
        if (mn > 59) begin
            mn -= C_MIN_HOUR;
            hrs++;
        end
        hr += hrs;
        if (hr > 23) begin
            hr -= C_HOUR_DAY;
            days++;
        end
        while (days >= C_DAYS_400) begin
            days -= C_DAYS_400;
            yr += C_YEARS_CYCLE;
        end
        while (days > 0) begin
            mlen = days_in_month(yr, mon);
            if (days >= mlen - dy + 1) begin
                days -= mlen - dy + 1;
                dy = 1;
                mon++;
                if (mon == 13) begin
                    mon = 1;
                    yr++;
                end
            end else begin
                dy += days;
                days = 0;
            end
        end
        if (two_digit) begin
            yr = yr % 100;
        end
        r.year = yr[13:0];
        r.month = mon[3:0];
        r.day = dy[4:0];
        r.hour = hr[4:0];
        r.minute = mn[5:0];
        return r;
    endfunction

    function automatic t_start start_of(int y, int mo, int d, int h, int mi, int add);
        t_start s;
        s.year = y[14:0];
        s.month = mo[3:0];
        s.day = d[4:0];
        s.hour = h[4:0];
        s.minute = mi[5:0];
        s.add = add;
        return s;
    endfunction

    function automatic t_stamp stamp_of(int y, int mo, int d, int h, int mi, t_status st);
        t_stamp r;
        r.year = y[13:0];
        r.month = mo[3:0];
        r.day = d[4:0];
        r.hour = h[4:0];
        r.minute = mi[5:0];
        r.status = st;
        return r;
    endfunction

    function automatic void direct_known(t_start s, t_stamp want);
        t_row row;
        row.start = s;
        row.known = 1'b1;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void direct_predicted(t_start s);
        t_row row;
        row.start = s;
        row.known = 1'b0;
        row.want = advance_stamp(s);
        directed_rows.push_back(row);
    endfunction

    function automatic t_start random_start();
        t_start      s;
        logic [31:0] raw;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            s.year = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 99))
                                                 : 15'($urandom_range(100, 16383));
            s.month = 4'($urandom_range(1, 12));
            s.day = 5'($urandom_range(1, days_in_month({17'd0, s.year}, 32'(s.month))));
            s.hour = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(0, 23));
            s.minute = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(0, 59));
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                s.add = $urandom_range(0, 10000);
            end else if (pick < 9) begin
                s.add = $urandom_range(0, 2000000);
            end else begin
                s.add = $urandom() & 32'h7FFF_FFFF;
            end
        end else begin
            raw = $urandom();
            s.year = raw[14:0];
            s.month = raw[18:15];
            s.day = raw[23:19];
            s.hour = raw[28:24];
            raw = $urandom();
            s.minute = raw[5:0];
            s.add = $urandom();
        end
        return s;
    endfunction

    task automatic send_item(t_start s, t_stamp want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_start_year <= s.year;
        i_start_month <= s.month;
        i_start_day <= s.day;
        i_start_hour <= s.hour;
        i_start_minute <= s.minute;
        i_add_minutes <= s.add;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        pending_stamps.push_back(want);
    endtask

    function automatic void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_stamps.size() == 0) begin
                $error("result item with no item outstanding");
                errors++;
            end else begin
                oldest = pending_stamps.pop_front();
                compare_field("result_year", 32'(oldest.year), 32'(o_result_year));
                compare_field("result_month", 32'(oldest.month), 32'(o_result_month));
                compare_field("result_day", 32'(oldest.day), 32'(o_result_day));
                compare_field("result_hour", 32'(oldest.hour), 32'(o_result_hour));
                compare_field("result_minute", 32'(oldest.minute), 32'(o_result_minute));
                compare_field("status", 32'(oldest.status), 32'(o_status));
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("date_time_add_minutes_unit regression: fail");
        $finish;
    end

    initial begin
        t_start s;
        direct_known(start_of(2024, 1, 1, 0, 0, -1), stamp_of(0, 0, 0, 0, 0, ST_NEG_MIN));
        direct_known(start_of(2024, 0, 0, 0, 0, 32'sh8000_0000),
                     stamp_of(0, 0, 0, 0, 0, ST_NEG_MIN));
        direct_known(start_of(2024, 0, 1, 12, 30, 0), stamp_of(0, 0, 0, 0, 0, ST_BAD_MONTH));
        direct_known(start_of(-1, 13, 1, 0, 0, 5), stamp_of(0, 0, 0, 0, 0, ST_BAD_MONTH));
        direct_known(start_of(2024, 15, 31, 31, 63, 32'sh7FFF_FFFF),
                     stamp_of(0, 0, 0, 0, 0, ST_BAD_MONTH));
        direct_known(start_of(-1, 1, 1, 0, 0, 0), stamp_of(0, 0, 0, 0, 0, ST_NEG_YEAR));
        direct_known(start_of(-16384, 2, 30, 0, 0, 100), stamp_of(0, 0, 0, 0, 0, ST_NEG_YEAR));
        direct_known(start_of(-9999, 12, 31, 23, 59, 0), stamp_of(0, 0, 0, 0, 0, ST_NEG_YEAR));
        direct_known(start_of(2024, 1, 0, 0, 0, 0), stamp_of(0, 0, 0, 0, 0, ST_BAD_DAY));
        direct_known(start_of(2023, 2, 29, 0, 0, 0), stamp_of(0, 0, 0, 0, 0, ST_BAD_DAY));
        direct_known(start_of(1900, 2, 29, 0, 0, 0), stamp_of(0, 0, 0, 0, 0, ST_BAD_DAY));
        direct_known(start_of(2024, 4, 31, 0, 0, 0), stamp_of(0, 0, 0, 0, 0, ST_BAD_DAY));
        direct_known(start_of(2024, 2, 29, 23, 59, 0), stamp_of(2024, 2, 29, 23, 59, ST_OK));
        direct_known(start_of(16383, 12, 31, 23, 59, 0),
                     stamp_of(16383, 12, 31, 23, 59, ST_OK));
        direct_known(start_of(0, 1, 1, 0, 0, 0), stamp_of(0, 1, 1, 0, 0, ST_OK));
        direct_predicted(start_of(2000, 2, 29, 0, 0, 0));
        direct_predicted(start_of(99, 12, 31, 23, 59, 1));
        direct_predicted(start_of(1999, 12, 31, 23, 59, 1));
        direct_predicted(start_of(1900, 2, 28, 23, 0, 60));
        direct_predicted(start_of(2023, 1, 31, 31, 63, 0));
        direct_predicted(start_of(2000, 1, 1, 0, 0, 210379680));
        direct_predicted(start_of(16383, 12, 31, 23, 59, 32'sh7FFF_FFFF));
        direct_predicted(start_of(50, 3, 15, 10, 20, 32'sh7FFF_FFFF));
        direct_predicted(start_of(1, 12, 31, 23, 59, 1439));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            send_item(directed_rows[k].start, directed_rows[k].want);
        end
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = idle_plan[phase];
            stall_pct = stall_plan[phase];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                s = random_start();
                send_item(s, advance_stamp(s));
            end
        end
        i_in_valid <= 1'b0;
        while (pending_stamps.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (64) @(posedge i_clk);
        if (errors == 0) begin
            $display("date_time_add_minutes_unit regression: pass");
        end else begin
            $display("date_time_add_minutes_unit regression: fail");
        end
        $finish;
    end

endmodule
